@@ src/sdspi_pkg.sv @@
package sdspi_pkg;

    localparam int unsigned POLL_W = 9;

    // Busy-release and response poll limits (range 1 to 255).
    localparam logic [POLL_W-1:0] READY_POLL_LIMIT    = 9'd200;
    localparam logic [POLL_W-1:0] RESPONSE_POLL_LIMIT = 9'd250;
    localparam logic [POLL_W-1:0] TAIL_BYTES          = 9'd4;

    localparam logic [7:0] IDLE_BYTE   = 8'hFF;
    localparam logic [7:0] START_BITS  = 8'h40;
    localparam logic [6:0] CRC7_POLY   = 7'h09;
    localparam logic [2:0] CRC_SLOT    = 3'd5;
    localparam logic [2:0] FRAME_BYTES = 3'd6;

    localparam logic [5:0] CMD_SEND_CSD      = 6'd9;
    localparam logic [5:0] CMD_SEND_IF_COND  = 6'd8;
    localparam logic [5:0] CMD_READ_SINGLE   = 6'd17;
    localparam logic [5:0] CMD_WRITE_SINGLE  = 6'd24;
    localparam logic [5:0] CMD_APP_CMD       = 6'd55;
    localparam logic [5:0] CMD_READ_OCR      = 6'd58;

    typedef enum logic {
        OP_START = 1'b0,
        OP_RX    = 1'b1
    } t_operation;

    typedef enum logic [1:0] {
        ACT_TRANSFER = 2'd0,
        ACT_DONE     = 2'd1,
        ACT_IGNORE   = 2'd2
    } t_action;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_DUMMY = 3'd1,
        PH_READY = 3'd2,
        PH_FRAME = 3'd3,
        PH_RESP  = 3'd4,
        PH_TAIL  = 3'd5
    } t_phase;

    // Shift one byte, MSB first, through the CRC7 register (x^7 + x^3 + 1).
    function automatic logic [6:0] crc7_feed(input logic [6:0] crc, input logic [7:0] data);
        logic [6:0] c;
        logic       fb;
        c = crc;
        for (int b = 7; b >= 0; b--) begin
            fb = data[b] ^ c[6];
            c  = {c[5:0], 1'b0};
            if (fb) begin
                c = c ^ CRC7_POLY;
            end
        end
        return c;
    endfunction

endpackage

@@ src/sdspi_ifs.sv @@
interface sdspi_cmd_if import sdspi_pkg::*; ();
    logic        valid;
    logic        ready;
    t_operation  operation;
    logic [5:0]  cmd_index;
    logic [31:0] argument;
    logic        want_crc;
    logic [7:0]  rx_byte;

    modport source (output valid, operation, cmd_index, argument, want_crc, rx_byte,
                    input ready);
    modport sink   (input valid, operation, cmd_index, argument, want_crc, rx_byte,
                    output ready);
endinterface

interface sdspi_rsp_if import sdspi_pkg::*; ();
    logic       valid;
    logic       ready;
    t_action    action;
    logic [7:0] tx_byte;
    logic       chip_select;
    logic [7:0] response;

    modport source (output valid, action, tx_byte, chip_select, response, input ready);
    modport sink   (input valid, action, tx_byte, chip_select, response, output ready);
endinterface

@@ src/sd_spi_command_transaction.sv @@
// SD card command sequencer for an SPI byte engine.
//
// i_cmd carries one item per transfer: either a start (command index,
// argument, CRC flag) or the byte the SPI engine shifted in during the
// previous exchange. o_rsp returns exactly one result per item: transfer
// tx_byte now, command done (with the R1 response, 0xFF when the card never
// answered), or item ignored (start while busy, received byte while idle).
// chip_select on every result is the select level after that step.
//
// The result is registered: the result of an item accepted at one edge is
// valid after that edge. Throughput is one item per cycle while the
// receiver takes each result; the whole step, including one CRC7 byte
// update, sits between the sequencer state and the result register.
//
// Reset idles the sequencer, deselects the card and sets the held response
// to 0xFF. When the receiver stalls, the result register holds its value and
// i_cmd.ready drops until the result is taken; an item is accepted in the
// same cycle the held result leaves.
module sd_spi_command_transaction
    import sdspi_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    sdspi_cmd_if.sink      i_cmd,
    sdspi_rsp_if.source    o_rsp
);

    // Sequencer state
    t_phase             r_phase,   n_phase;
    logic [POLL_W-1:0]  r_poll,    n_poll;
    logic [2:0]         r_frame,   n_frame;
    logic [5:0]         r_cmd,     n_cmd;
    logic [31:0]        r_arg,     n_arg;
    logic               r_crc_en,  n_crc_en;
    logic [6:0]         r_crc,     n_crc;
    logic               r_select,  n_select;
    logic [7:0]         r_resp,    n_resp;

    // Result register
    logic               r_out_valid;
    t_action            r_action,  n_action;
    logic [7:0]         r_tx,      n_tx;
    logic               r_cs;
    logic [7:0]         r_out_resp;

    logic               in_fire;
    logic [2:0]         frame_idx;
    logic [6:0]         frame_crc_in;
    logic [7:0]         frame_byte;
    logic [6:0]         frame_crc_out;
    logic               keeps_select;
    logic               has_tail;

    assign in_fire     = i_cmd.valid && i_cmd.ready;
    assign i_cmd.ready = !r_out_valid || o_rsp.ready;

    assign keeps_select = (r_cmd == CMD_APP_CMD) || (r_cmd == CMD_SEND_CSD) ||
                          (r_cmd == CMD_READ_SINGLE) || (r_cmd == CMD_WRITE_SINGLE);
    assign has_tail     = (r_cmd == CMD_SEND_IF_COND) || (r_cmd == CMD_READ_OCR);

    // Frame byte: leaving the ready poll restarts the frame at byte zero.
    always_comb begin
        frame_idx    = (r_phase == PH_READY) ? 3'd0 : r_frame;
        frame_crc_in = (r_phase == PH_READY) ? 7'd0 : r_crc;
        case (frame_idx)
            3'd0:    frame_byte = START_BITS | {2'b00, r_cmd};
            3'd1:    frame_byte = r_arg[31:24];
            3'd2:    frame_byte = r_arg[23:16];
            3'd3:    frame_byte = r_arg[15:8];
            3'd4:    frame_byte = r_arg[7:0];
            default: frame_byte = r_crc_en ? {frame_crc_in, 1'b1} : 8'h00;
        endcase
        frame_crc_out = (frame_idx < CRC_SLOT) ? crc7_feed(frame_crc_in, frame_byte)
                                               : frame_crc_in;
    end

    // Next state
    always_comb begin
        n_phase  = r_phase;
        n_poll   = r_poll;
        n_frame  = r_frame;
        n_cmd    = r_cmd;
        n_arg    = r_arg;
        n_crc_en = r_crc_en;
        n_crc    = r_crc;
        n_select = r_select;
        n_resp   = r_resp;
        if (i_cmd.operation == OP_START) begin
            if (r_phase == PH_IDLE) begin
                n_cmd    = i_cmd.cmd_index;
                n_arg    = i_cmd.argument;
                n_crc_en = i_cmd.want_crc;
                n_resp   = IDLE_BYTE;
                n_crc    = 7'd0;
                n_frame  = 3'd0;
                n_poll   = '0;
                n_select = 1'b1;
                n_phase  = PH_DUMMY;
            end
        end else begin
            unique case (r_phase)
                PH_DUMMY: begin
                    n_poll  = '0;
                    n_phase = PH_READY;
                end
                PH_READY: begin
                    if (i_cmd.rx_byte != IDLE_BYTE && r_poll <= READY_POLL_LIMIT) begin
                        n_poll = r_poll + 1'b1;
                    end else begin
                        n_crc   = frame_crc_out;
                        n_frame = frame_idx + 1'b1;
                        n_phase = PH_FRAME;
                    end
                end
                PH_FRAME: begin
                    if (r_frame < FRAME_BYTES) begin
                        n_crc   = frame_crc_out;
                        n_frame = r_frame + 1'b1;
                    end else begin
                        n_poll  = '0;
                        n_phase = PH_RESP;
                    end
                end
                PH_RESP: begin
                    if (i_cmd.rx_byte == IDLE_BYTE && r_poll < RESPONSE_POLL_LIMIT) begin
                        n_poll = r_poll + 1'b1;
                    end else begin
                        n_resp = i_cmd.rx_byte;
                        if (has_tail) begin
                            n_poll  = 9'd1;
                            n_phase = PH_TAIL;
                        end else begin
                            n_select = keeps_select;
                            n_phase  = PH_IDLE;
                        end
                    end
                end
                PH_TAIL: begin
                    if (r_poll < TAIL_BYTES) begin
                        n_poll = r_poll + 1'b1;
                    end else begin
                        n_select = keeps_select;
                        n_phase  = PH_IDLE;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    // Result fields
    always_comb begin
        n_action = ACT_IGNORE;
        n_tx     = 8'h00;
        if (i_cmd.operation == OP_START) begin
            if (r_phase == PH_IDLE) begin
                n_action = ACT_TRANSFER;
                n_tx     = IDLE_BYTE;
            end
        end else begin
            unique case (r_phase)
                PH_DUMMY: begin
                    n_action = ACT_TRANSFER;
                    n_tx     = IDLE_BYTE;
                end
                PH_READY: begin
                    n_action = ACT_TRANSFER;
                    if (i_cmd.rx_byte != IDLE_BYTE && r_poll <= READY_POLL_LIMIT) begin
                        n_tx = IDLE_BYTE;
                    end else begin
                        n_tx = frame_byte;
                    end
                end
                PH_FRAME: begin
                    n_action = ACT_TRANSFER;
                    n_tx     = (r_frame < FRAME_BYTES) ? frame_byte : IDLE_BYTE;
                end
                PH_RESP: begin
                    if ((i_cmd.rx_byte == IDLE_BYTE && r_poll < RESPONSE_POLL_LIMIT)
                        || has_tail) begin
                        n_action = ACT_TRANSFER;
                        n_tx     = IDLE_BYTE;
                    end else begin
                        n_action = ACT_DONE;
                    end
                end
                PH_TAIL: begin
                    if (r_poll < TAIL_BYTES) begin
                        n_action = ACT_TRANSFER;
                        n_tx     = IDLE_BYTE;
                    end else begin
                        n_action = ACT_DONE;
                    end
                end
                default: begin
                    n_action = ACT_IGNORE;
                end
            endcase
        end
    end

    // Advance the sequencer only on an accepted transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_poll   <= '0;
            r_frame  <= '0;
            r_cmd    <= '0;
            r_select <= 1'b0;
            r_resp   <= IDLE_BYTE;
        end else if (in_fire) begin
            r_phase  <= n_phase;
            r_poll   <= n_poll;
            r_frame  <= n_frame;
            r_cmd    <= n_cmd;
            r_select <= n_select;
            r_resp   <= n_resp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_arg    <= n_arg;
            r_crc_en <= n_crc_en;
            r_crc    <= n_crc;
        end
    end

    // Result register: load on accept, hold while the receiver stalls.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_action   <= n_action;
            r_tx       <= n_tx;
            r_cs       <= n_select;
            r_out_resp <= n_resp;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.action      = r_action;
    assign o_rsp.tx_byte     = r_tx;
    assign o_rsp.chip_select = r_cs;
    assign o_rsp.response    = r_out_resp;

    // The card stays selected for the whole command.
    a_select_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase != PH_IDLE |-> r_select)
        else $error("card deselected during a command");

    a_frame_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frame <= FRAME_BYTES)
        else $error("frame index past the CRC byte");

    a_tail_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_TAIL |-> (r_poll >= 9'd1 && r_poll <= TAIL_BYTES))
        else $error("tail byte count out of range");

    a_resp_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_RESP |-> r_poll <= RESPONSE_POLL_LIMIT)
        else $error("response poll count overran");

    // A done result leaves the sequencer idle and carries the held response.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && n_action == ACT_DONE |=> r_phase == PH_IDLE && r_out_resp == r_resp)
        else $error("command done but sequencer not idle");

endmodule

@@ bench/sdspi_sequence_checker.sv @@
`timescale 1ns / 100ps

module sdspi_sequence_checker
    import sdspi_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    sdspi_cmd_if i_cmd,
    sdspi_rsp_if i_rsp,
    output int   o_fail_count,
    output int   o_due_count
);

    typedef struct packed {
        t_action    action;
        logic [7:0] tx_byte;
        logic       chip_select;
        logic [7:0] response;
    } t_spi_step;

    // Predicted sequencer state.
    t_phase            seq_phase;
    logic [POLL_W-1:0] poll_count;
    logic [2:0]        frame_idx;
    logic [5:0]        cmd_held;
    logic [31:0]       arg_held;
    logic              crc_wanted;
    logic [6:0]        crc_acc;
    logic              card_selected;
    logic [7:0]        r1_held;

    t_spi_step due_steps[$];
    int        fail_count = 0;

    task automatic flag_error(input string msg);
        $display("ERROR %0t: %s", $time, msg);
        fail_count++;
    endtask

    function automatic logic [6:0] fold_crc7(input logic [6:0] crc, input logic [7:0] data);
        logic [6:0] acc;
        logic       carry;
        acc = crc;
        for (int i = 0; i < 8; i++) begin
            carry = acc[6] ^ data[7 - i];
            acc   = {acc[5:0], 1'b0} ^ (carry ? CRC7_POLY : 7'h00);
        end
        return acc;
    endfunction

    // Next byte of the six-byte frame; the first five feed the CRC.
    function automatic logic [7:0] emit_frame_byte();
        logic [7:0] b;
        case (frame_idx)
            3'd0: b = START_BITS | {2'b00, cmd_held};
            3'd1: b = arg_held[31:24];
            3'd2: b = arg_held[23:16];
            3'd3: b = arg_held[15:8];
            3'd4: b = arg_held[7:0];
            default: b = crc_wanted ? {crc_acc, 1'b1} : 8'h00;
        endcase
        if (frame_idx < CRC_SLOT) crc_acc = fold_crc7(crc_acc, b);
        frame_idx = frame_idx + 3'd1;
        return b;
    endfunction

    function automatic t_action close_command();
        seq_phase     = PH_IDLE;
        card_selected = (cmd_held == CMD_APP_CMD) || (cmd_held == CMD_SEND_CSD) ||
                        (cmd_held == CMD_READ_SINGLE) || (cmd_held == CMD_WRITE_SINGLE);
        return ACT_DONE;
    endfunction

    function automatic t_spi_step sequence_step(input t_operation op, input logic [5:0] cmd,
                                                input logic [31:0] arg, input logic crc_on,
                                                input logic [7:0] rx);
        t_action    act;
        logic [7:0] tx;
        t_spi_step  r;
        act = ACT_TRANSFER;
        tx  = IDLE_BYTE;
        if (op == OP_START) begin
            if (seq_phase != PH_IDLE) begin
                act = ACT_IGNORE;
            end else begin
                cmd_held      = cmd;
                arg_held      = arg;
                crc_wanted    = crc_on;
                r1_held       = IDLE_BYTE;
                crc_acc       = '0;
                frame_idx     = '0;
                poll_count    = '0;
                card_selected = 1'b1;
                seq_phase     = PH_DUMMY;
            end
        end else begin
            case (seq_phase)
                PH_DUMMY: begin
                    poll_count = '0;
                    seq_phase  = PH_READY;
                end
                PH_READY: begin
                    if (rx != IDLE_BYTE && poll_count <= READY_POLL_LIMIT) begin
                        poll_count++;
                    end else begin
                        frame_idx = '0;
                        crc_acc   = '0;
                        seq_phase = PH_FRAME;
                        tx        = emit_frame_byte();
                    end
                end
                PH_FRAME: begin
                    if (frame_idx < FRAME_BYTES) begin
                        tx = emit_frame_byte();
                    end else begin
                        poll_count = '0;
                        seq_phase  = PH_RESP;
                    end
                end
                PH_RESP: begin
                    if (rx == IDLE_BYTE && poll_count < RESPONSE_POLL_LIMIT) begin
                        poll_count++;
                    end else begin
                        r1_held = rx;
                        if (cmd_held == CMD_SEND_IF_COND || cmd_held == CMD_READ_OCR) begin
                            poll_count = 9'd1;
                            seq_phase  = PH_TAIL;
                        end else begin
                            act = close_command();
                        end
                    end
                end
                PH_TAIL: begin
                    if (poll_count < TAIL_BYTES) poll_count++;
                    else act = close_command();
                end
                default: begin
                    seq_phase = PH_IDLE;
                    act       = ACT_IGNORE;
                end
            endcase
        end
        if (act != ACT_TRANSFER) tx = 8'h00;
        r.action      = act;
        r.tx_byte     = tx;
        r.chip_select = card_selected;
        r.response    = r1_held;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_spi_step want;
        if (!i_rst_n) begin
            seq_phase     = PH_IDLE;
            poll_count    = '0;
            frame_idx     = '0;
            cmd_held      = '0;
            arg_held      = '0;
            crc_wanted    = 1'b0;
            crc_acc       = '0;
            card_selected = 1'b0;
            r1_held       = IDLE_BYTE;
            due_steps.delete();
        end else begin
            // Retire first: a result leaving now belongs to an earlier transfer.
            if (i_rsp.valid && i_rsp.ready) begin
                if (due_steps.size() == 0) begin
                    flag_error("result with nothing outstanding");
                end else begin
                    want = due_steps.pop_front();
                    if (i_rsp.action !== want.action)
                        flag_error($sformatf("action got %0d want %0d",
                                             i_rsp.action, want.action));
                    if (i_rsp.tx_byte !== want.tx_byte)
                        flag_error($sformatf("tx_byte got %02h want %02h",
                                             i_rsp.tx_byte, want.tx_byte));
                    if (i_rsp.chip_select !== want.chip_select)
                        flag_error($sformatf("chip_select got %0b want %0b",
                                             i_rsp.chip_select, want.chip_select));
                    if (i_rsp.response !== want.response)
                        flag_error($sformatf("response got %02h want %02h",
                                             i_rsp.response, want.response));
                end
            end
            if (i_cmd.valid && i_cmd.ready) begin
                due_steps.push_back(sequence_step(i_cmd.operation, i_cmd.cmd_index,
                                                  i_cmd.argument, i_cmd.want_crc,
                                                  i_cmd.rx_byte));
            end
        end
        o_due_count  <= due_steps.size();
        o_fail_count <= fail_count;
    end

endmodule

@@ bench/tb_sd_spi_command_transaction.sv @@
`timescale 1ns / 100ps

module tb_sd_spi_command_transaction;
    import sdspi_pkg::*;

    // Generous ceiling on the run length in cycles.
    localparam int CYCLE_LIMIT   = 1_000_000;
    // Counted items per traffic phase, the forced poll runs included.
    localparam int PHASE_ITEMS   = 20;
    // The block answers in the cycle after a transfer; leave a margin.
    localparam int SETTLE_CYCLES = 16;

    logic i_clk;
    logic i_rst_n;

    sdspi_cmd_if cmd_bus ();
    sdspi_rsp_if rsp_bus ();

    int fail_count;
    int due_count;
    int cycle_count   = 0;
    int send_idle_pct = 0;
    int rsp_stall_pct = 0;
    int stray_pct     = 0;
    int planned_items = 0;

    sd_spi_command_transaction uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_bus),
        .o_rsp   (rsp_bus)
    );

    sdspi_sequence_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd_bus),
        .i_rsp        (rsp_bus),
        .o_fail_count (fail_count),
        .o_due_count  (due_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Abort the run if it hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Stall the result channel at the rate of the current phase.
    always @(posedge i_clk) begin
        rsp_bus.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
    end

    // Offer one item, with random idle cycles ahead of it, and hold it
    // until the transfer happens. Return in the step of the accepting edge.
    task automatic push_item(input t_operation op, input logic [5:0] cmd,
                             input logic [31:0] arg, input logic crc_on,
                             input logic [7:0] rx);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            cmd_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_bus.valid     <= 1'b1;
        cmd_bus.operation <= op;
        cmd_bus.cmd_index <= cmd;
        cmd_bus.argument  <= arg;
        cmd_bus.want_crc  <= crc_on;
        cmd_bus.rx_byte   <= rx;
        @(posedge i_clk);
        while (!cmd_bus.ready) @(posedge i_clk);
    endtask

    // Feed one received byte; now and then slip in a start, which a busy
    // sequencer has to drop. Fields unused on a received byte stay random.
    task automatic send_rx(input logic [7:0] b);
        if ($urandom_range(0, 99) < stray_pct) begin
            push_item(OP_START, 6'($urandom_range(0, 63)), $urandom,
                      1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
        end
        push_item(OP_RX, 6'($urandom_range(0, 63)), $urandom,
                  1'($urandom_range(0, 1)), b);
        planned_items++;
    endtask

    task automatic open_command(input logic [5:0] cmd, input logic [31:0] arg,
                                input logic crc_on);
        push_item(OP_START, cmd, arg, crc_on, 8'($urandom_range(0, 255)));
        planned_items++;
    endtask

    // Walk one command to its end as a well-behaved card would: dummy byte,
    // busy reads, release, frame, response wait, answer, optional tail.
    // busy_reads beyond the ready limit or resp_waits at the response limit
    // run the poll out, and the closing byte is then random.
    task automatic finish_command(input logic [5:0] cmd, input int busy_reads,
                                  input int resp_waits, input logic [7:0] answer);
        send_rx(8'($urandom_range(0, 255)));
        repeat (busy_reads) send_rx(8'($urandom_range(0, 254)));
        send_rx(busy_reads > int'(READY_POLL_LIMIT) ? 8'($urandom_range(0, 255)) : IDLE_BYTE);
        repeat (FRAME_BYTES) send_rx(8'($urandom_range(0, 255)));
        repeat (resp_waits) send_rx(IDLE_BYTE);
        send_rx(answer);
        if (cmd == CMD_SEND_IF_COND || cmd == CMD_READ_OCR) begin
            repeat (TAIL_BYTES) send_rx(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic run_command(input logic [5:0] cmd, input logic [31:0] arg,
                               input logic crc_on, input int busy_reads,
                               input int resp_waits, input logic [7:0] answer);
        open_command(cmd, arg, crc_on);
        finish_command(cmd, busy_reads, resp_waits, answer);
    endtask

    task automatic random_command();
        logic [5:0]  cmd;
        logic [31:0] arg;
        logic [7:0]  answer;
        int          busy;
        int          waits;
        int          r;
        // Bias toward the commands that keep select or clock a tail.
        if ($urandom_range(0, 1) == 0) begin
            cmd = 6'($urandom_range(0, 63));
        end else begin
            case ($urandom_range(0, 5))
                0: cmd = CMD_SEND_IF_COND;
                1: cmd = CMD_READ_OCR;
                2: cmd = CMD_APP_CMD;
                3: cmd = CMD_SEND_CSD;
                4: cmd = CMD_READ_SINGLE;
                default: cmd = CMD_WRITE_SINGLE;
            endcase
        end
        case ($urandom_range(0, 7))
            0: arg = '0;
            1: arg = '1;
            default: arg = $urandom;
        endcase
        // Mostly short busy periods; rarely sit right at the ready limit.
        r = $urandom_range(0, 59);
        if (r == 0)      busy = int'(READY_POLL_LIMIT);
        else if (r < 30) busy = 0;
        else             busy = $urandom_range(1, 4);
        r = $urandom_range(0, 59);
        if (r == 0)      waits = int'(RESPONSE_POLL_LIMIT);
        else if (r == 1) waits = int'(RESPONSE_POLL_LIMIT) - 1;
        else if (r < 30) waits = 0;
        else             waits = $urandom_range(1, 5);
        if (waits >= int'(RESPONSE_POLL_LIMIT)) answer = 8'($urandom_range(0, 255));
        else                                    answer = 8'($urandom_range(0, 254));
        run_command(cmd, arg, 1'($urandom_range(0, 1)), busy, waits, answer);
    endtask

    // Stray bytes with no command open, or a command cut short.
    task automatic random_noise();
        int n;
        n = $urandom_range(1, 4);
        if ($urandom_range(0, 2) == 0) begin
            open_command(6'($urandom_range(0, 63)), $urandom, 1'($urandom_range(0, 1)));
        end
        repeat (n) send_rx(8'($urandom_range(0, 255)));
    endtask

    // Drop valid and hold off until every result has been taken.
    task automatic wait_drained();
        cmd_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (due_count != 0) @(posedge i_clk);
    endtask

    initial begin
        int stop_at;
        int mark;
        i_rst_n           <= 1'b0;
        cmd_bus.valid     <= 1'b0;
        cmd_bus.operation <= OP_START;
        cmd_bus.cmd_index <= '0;
        cmd_bus.argument  <= '0;
        cmd_bus.want_crc  <= 1'b0;
        cmd_bus.rx_byte   <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: received bytes while idle must be dropped.
        push_item(OP_RX, 6'h00, 32'h0000_0000, 1'b0, 8'h00);
        push_item(OP_RX, 6'h3F, 32'hFFFF_FFFF, 1'b1, IDLE_BYTE);
        // GO_IDLE with its well-known CRC byte, answer on the first poll.
        run_command(6'd0, 32'h0000_0000, 1'b1, 0, 0, 8'h01);
        // SEND_IF_COND with a start arriving mid-command, one busy read,
        // one empty response poll and the four tail bytes.
        open_command(CMD_SEND_IF_COND, 32'h0000_01AA, 1'b1);
        push_item(OP_START, 6'h3F, 32'hFFFF_FFFF, 1'b0, IDLE_BYTE);
        finish_command(CMD_SEND_IF_COND, 1, 1, 8'h01);
        wait_drained();

        // Random traffic in four pacing phases, drained between phases.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
                1: begin send_idle_pct = 66; rsp_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  rsp_stall_pct = 66; end
                default: begin send_idle_pct = 32; rsp_stall_pct = 32; end
            endcase
            stray_pct = 4;
            mark      = planned_items;
            // Run each poll out once: a card that never releases busy,
            // then one that never answers.
            if (ph == 1) run_command(CMD_READ_SINGLE, $urandom, 1'b1,
                                     int'(READY_POLL_LIMIT) + 1, 0, 8'h00);
            if (ph == 2) run_command(CMD_READ_OCR, $urandom, 1'b0,
                                     0, int'(RESPONSE_POLL_LIMIT), IDLE_BYTE);
            stop_at = mark + PHASE_ITEMS;
            while (planned_items < stop_at) begin
                if ($urandom_range(0, 19) == 0) random_noise();
                else                            random_command();
            end
            wait_drained();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && due_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

@@ sd_spi_command_transaction.f @@
src/sdspi_pkg.sv
src/sdspi_ifs.sv
src/sd_spi_command_transaction.sv
bench/sdspi_sequence_checker.sv
bench/tb_sd_spi_command_transaction.sv
